### rtl/fpmd_pkg.sv
// Shared types and constants for the fixed-point multiply/divide unit.
// No dependencies.
`default_nettype none
package fpmd_pkg;

	// Request codes; the two unused codes fall to default arms
	typedef enum logic [2:0] {
		OP_MUL_Q8  = 3'd0,
		OP_DIV_Q8  = 3'd1,
		OP_MUL_Q16 = 3'd2,
		OP_DIV_Q16 = 3'd3,
		OP_Q16_Q8  = 3'd4,
		OP_Q8_Q16  = 3'd5
	} fpmd_op_t;

	localparam int unsigned Q8_FRAC    = 8;
	localparam int unsigned Q16_FRAC   = 16;
	localparam int unsigned OPND_W     = 32;
	localparam int unsigned QUO_W      = 48;  // widest dividend: 32-bit magnitude shifted by 16
	localparam int unsigned DIV_STAGES = QUO_W;

	// Word carried through the divider stages
	typedef struct packed {
		fpmd_op_t          op;
		logic              neg;
		logic              dz;
		logic [OPND_W-1:0] ma;
		logic [OPND_W-1:0] mb;
		logic [OPND_W-1:0] rem;
		logic [QUO_W-1:0]  quo;
	} fpmd_div_t;

	// Word leaving the multiply stage
	typedef struct packed {
		fpmd_op_t            op;
		logic                neg;
		logic                dz;
		logic [OPND_W-1:0]   ma;
		logic [QUO_W-1:0]    quo;
		logic [2*OPND_W-1:0] prod;
	} fpmd_mul_t;

endpackage
`default_nettype wire

### rtl/fpmd_prep.sv
// Input stage: operand magnitudes, result sign, zero-divisor flag, dividend.
// Depends on fpmd_pkg.
`default_nettype none
module fpmd_prep (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             en,
	input  wire logic             in_valid,
	input  wire logic [2:0]       req_type,
	input  wire logic [31:0]      operand_a,
	input  wire logic [31:0]      operand_b,
	output logic                  out_valid,
	output fpmd_pkg::fpmd_div_t   out_word
);
	import fpmd_pkg::*;

	fpmd_op_t          op;
	logic              q8_a, q8_b, conv, is_div;
	logic [15:0]       mag16_a, mag16_b;
	logic [31:0]       mag32_a, mag32_b;
	fpmd_div_t         nxt;
	logic              valid_s1;
	fpmd_div_t         word_s1;

	assign op = fpmd_op_t'(req_type);

	// Two's complement magnitudes at both widths
	assign mag16_a = operand_a[15] ? (~operand_a[15:0] + 16'd1) : operand_a[15:0];
	assign mag16_b = operand_b[15] ? (~operand_b[15:0] + 16'd1) : operand_b[15:0];
	assign mag32_a = operand_a[31] ? (~operand_a + 32'd1) : operand_a;
	assign mag32_b = operand_b[31] ? (~operand_b + 32'd1) : operand_b;

	// Decode request and build the divider word
	always_comb begin
		q8_a   = (op == OP_MUL_Q8) || (op == OP_DIV_Q8) || (op == OP_Q8_Q16);
		q8_b   = (op == OP_MUL_Q8) || (op == OP_DIV_Q8);
		conv   = (op == OP_Q16_Q8) || (op == OP_Q8_Q16);
		is_div = (op == OP_DIV_Q8) || (op == OP_DIV_Q16);
		nxt.op  = op;
		nxt.ma  = q8_a ? {16'd0, mag16_a} : mag32_a;
		nxt.mb  = q8_b ? {16'd0, mag16_b} : mag32_b;
		nxt.rem = '0;
		if (conv) begin
			nxt.neg = q8_a ? operand_a[15] : operand_a[31];
		end else if (q8_b) begin
			nxt.neg = operand_a[15] ^ operand_b[15];
		end else begin
			nxt.neg = operand_a[31] ^ operand_b[31];
		end
		nxt.dz = is_div && (nxt.mb == '0);
		case (op)
			OP_DIV_Q8:  nxt.quo = {8'd0, nxt.ma, 8'd0};
			OP_DIV_Q16: nxt.quo = {nxt.ma, 16'd0};
			default:    nxt.quo = '0;
		endcase
	end

	// Hold valid under reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			word_s1 <= nxt;
		end
	end

	assign out_valid = valid_s1;
	assign out_word  = word_s1;

endmodule
`default_nettype wire

### rtl/fpmd_div_stage.sv
// One restoring-division step: one quotient bit per stage.
// Depends on fpmd_pkg.
`default_nettype none
module fpmd_div_stage (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                en,
	input  wire logic                in_valid,
	input  wire fpmd_pkg::fpmd_div_t in_word,
	output logic                     out_valid,
	output fpmd_pkg::fpmd_div_t      out_word
);
	import fpmd_pkg::*;

	logic [OPND_W:0]   trial;
	logic [OPND_W:0]   diff;
	logic              ge;
	fpmd_div_t         nxt;
	logic              valid_s;
	fpmd_div_t         word_s;

	// Shift in the next dividend bit and try the subtract
	always_comb begin
		trial = {in_word.rem, in_word.quo[QUO_W-1]};
		diff  = trial - {1'b0, in_word.mb};
		ge    = (trial >= {1'b0, in_word.mb});
		nxt   = in_word;
		nxt.rem = ge ? diff[OPND_W-1:0] : trial[OPND_W-1:0];
		nxt.quo = {in_word.quo[QUO_W-2:0], ge};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= 1'b0;
		end else if (en) begin
			valid_s <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			word_s <= nxt;
		end
	end

	assign out_valid = valid_s;
	assign out_word  = word_s;

endmodule
`default_nettype wire

### rtl/fpmd_mul.sv
// Multiply stage: registered 32x32 product of the operand magnitudes.
// Depends on fpmd_pkg.
`default_nettype none
module fpmd_mul (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                en,
	input  wire logic                in_valid,
	input  wire fpmd_pkg::fpmd_div_t in_word,
	output logic                     out_valid,
	output fpmd_pkg::fpmd_mul_t      out_word
);
	import fpmd_pkg::*;

	logic [2*OPND_W-1:0] prod;
	logic                valid_s;
	fpmd_mul_t           word_s;

	assign prod = {{OPND_W{1'b0}}, in_word.ma} * {{OPND_W{1'b0}}, in_word.mb};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= 1'b0;
		end else if (en) begin
			valid_s <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			word_s.op   <= in_word.op;
			word_s.neg  <= in_word.neg;
			word_s.dz   <= in_word.dz;
			word_s.ma   <= in_word.ma;
			word_s.quo  <= in_word.quo;
			word_s.prod <= prod;
		end
	end

	assign out_valid = valid_s;
	assign out_word  = word_s;

endmodule
`default_nettype wire

### rtl/fpmd_finish.sv
// Output stage: pick the magnitude, apply sign, wrap to format, set flags.
// Depends on fpmd_pkg.
`default_nettype none
module fpmd_finish (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                en,
	input  wire logic                in_valid,
	input  wire fpmd_pkg::fpmd_mul_t in_word,
	output logic                     out_valid,
	output logic [31:0]              result_value,
	output logic                     divide_by_zero,
	output logic                     overflowed
);
	import fpmd_pkg::*;

	logic [QUO_W-1:0]  mag;
	logic [QUO_W-1:0]  lim;
	logic              w16, known;
	logic [31:0]       bits;
	logic [31:0]       res;
	logic              ov;
	logic              valid_s;
	logic [31:0]       res_s;
	logic              dz_s, ov_s;

	// Select magnitude and format width per request
	always_comb begin
		known = 1'b1;
		w16   = 1'b0;
		case (in_word.op)
			OP_MUL_Q8: begin
				mag = in_word.prod[QUO_W+Q8_FRAC-1:Q8_FRAC];
				w16 = 1'b1;
			end
			OP_DIV_Q8: begin
				mag = in_word.quo;
				w16 = 1'b1;
			end
			OP_MUL_Q16: mag = in_word.prod[QUO_W+Q16_FRAC-1:Q16_FRAC];
			OP_DIV_Q16: mag = in_word.quo;
			OP_Q16_Q8: begin
				mag = {24'd0, in_word.ma[31:8]};
				w16 = 1'b1;
			end
			OP_Q8_Q16:  mag = {8'd0, in_word.ma, 8'd0};
			default: begin
				mag   = '0;
				known = 1'b0;
			end
		endcase
	end

	// Wrap signed result and flag values outside the format
	always_comb begin
		lim  = w16 ? 48'h8000 : 48'h8000_0000;
		bits = in_word.neg ? (~mag[31:0] + 32'd1) : mag[31:0];
		ov   = in_word.neg ? (mag > lim) : (mag >= lim);
		res  = w16 ? {{16{bits[15]}}, bits[15:0]} : bits;
		if (!known || in_word.dz) begin
			res = '0;
			ov  = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= 1'b0;
		end else if (en) begin
			valid_s <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_s <= res;
			dz_s  <= in_word.dz & known;
			ov_s  <= ov;
		end
	end

	assign out_valid      = valid_s;
	assign result_value   = res_s;
	assign divide_by_zero = dz_s;
	assign overflowed     = ov_s;

endmodule
`default_nettype wire

### rtl/fixed_point_mul_div_unit.sv
// Signed Q8.8 / Q16.16 multiply, divide and format conversion unit.
// Channels: slave side s_* takes one request word per handshake; tdata holds
// operand_a in the low 32 bits and operand_b above it, tuser holds req_type.
// Master side m_* returns one result word per request, in request order;
// tdata holds result_value, tuser holds divide_by_zero then overflowed.
// Pipeline: 51 register stages (one input stage, 48 restoring-division stages
// at one quotient bit each, a multiply stage and the output register). Every
// request runs the full pipeline.
// Throughput: one word per cycle while m_tready is high.
// Stall: all stages advance together; with m_tvalid high and m_tready low the
// whole pipeline holds and s_tready drops, so nothing is lost or repeated.
// Reset: arst_n clears all stage valid bits at once; the unit takes requests
// as soon as reset is released.
// Divide by zero returns 0 with divide_by_zero set; unused request codes
// return 0 with both flags clear.
// Depends on fpmd_pkg, fpmd_prep, fpmd_div_stage, fpmd_mul, fpmd_finish.
`default_nettype none
module fixed_point_mul_div_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [63:0] s_tdata,   // [31:0] operand_a, [63:32] operand_b
	input  wire logic [2:0]  s_tuser,   // [2:0] req_type
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata,   // [31:0] result_value
	output logic [1:0]       m_tuser    // [0] divide_by_zero, [1] overflowed
);
	import fpmd_pkg::*;

	logic              en;
	logic              vld [DIV_STAGES+1];
	fpmd_div_t         wrd [DIV_STAGES+1];
	logic              mul_valid;
	fpmd_mul_t         mul_word;
	logic              dz, ov;

	// Advance the pipeline whenever the output register is free or drains
	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	fpmd_prep u_prep (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (s_tvalid),
		.req_type  (s_tuser),
		.operand_a (s_tdata[31:0]),
		.operand_b (s_tdata[63:32]),
		.out_valid (vld[0]),
		.out_word  (wrd[0])
	);

	// Divider chain
	for (genvar i = 0; i < DIV_STAGES; i++) begin : g_div
		fpmd_div_stage u_stage (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.in_valid  (vld[i]),
			.in_word   (wrd[i]),
			.out_valid (vld[i+1]),
			.out_word  (wrd[i+1])
		);
	end

	fpmd_mul u_mul (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (vld[DIV_STAGES]),
		.in_word   (wrd[DIV_STAGES]),
		.out_valid (mul_valid),
		.out_word  (mul_word)
	);

	fpmd_finish u_finish (
		.clk            (clk),
		.arst_n         (arst_n),
		.en             (en),
		.in_valid       (mul_valid),
		.in_word        (mul_word),
		.out_valid      (m_tvalid),
		.result_value   (m_tdata),
		.divide_by_zero (dz),
		.overflowed     (ov)
	);

	assign m_tuser = {ov, dz};

	// A zero-divisor result carries value 0 and no overflow
	a_dz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && dz |-> (m_tdata == 32'd0) && !ov)
		else $error("divide_by_zero result not zero");

	// A word in the multiply stage lands in the output register on advance
	a_mul_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		en && mul_valid |=> m_tvalid)
		else $error("word lost between multiply and output stage");

	// A stalled output freezes the divider chain tail
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(mul_valid) && $stable(vld[DIV_STAGES]))
		else $error("pipeline moved during stall");

endmodule
`default_nettype wire

### verif/fpmd_checker.sv
// Result checker for the fixed-point multiply/divide unit: watches both stream
// channels, predicts each result word and compares in order. Depends on fpmd_pkg.
`timescale 1ns / 100ps
`default_nettype none
module fpmd_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	input  wire logic        s_tready,
	input  wire logic [63:0] s_tdata,
	input  wire logic [2:0]  s_tuser,
	input  wire logic        m_tvalid,
	input  wire logic        m_tready,
	input  wire logic [31:0] m_tdata,
	input  wire logic [1:0]  m_tuser,
	output int               errors,
	output int               pending
);
	import fpmd_pkg::*;

	typedef struct packed {
		logic [31:0] value;
		logic        dz;
		logic        ov;
	} fx_result_t;

	fx_result_t results_due[$];

	// Magnitude of the low w bits taken as two's complement
	function automatic logic [63:0] fx_mag(input logic [31:0] x, input int w,
		output logic neg);
		logic [63:0] v;
		v = (w == 16) ? {48'd0, x[15:0]} : {32'd0, x};
		neg = v[w-1];
		if (neg)
			v = ((~v) + 64'd1) & ((64'd1 << w) - 64'd1);
		return v;
	endfunction

	// Wrap sign*mag to w bits and flag overflow
	function automatic fx_result_t fx_wrap(input logic neg, input logic [63:0] mag,
		input int w);
		fx_result_t r;
		logic [63:0] lim;
		logic [63:0] bits;
		lim = 64'd1 << (w - 1);
		bits = neg ? (64'd0 - mag) : mag;
		r.dz = 1'b0;
		r.ov = neg ? (mag > lim) : (mag >= lim);
		r.value = (w == 16) ? {{16{bits[15]}}, bits[15:0]} : bits[31:0];
		return r;
	endfunction

	function automatic fx_result_t fx_compute(input logic [2:0] op,
		input logic [31:0] a, input logic [31:0] b);
		fx_result_t r;
		logic na, nb;
		logic [63:0] ma, mb;
		r = '0;
		case (op)
			OP_MUL_Q8, OP_DIV_Q8: begin
				ma = fx_mag(a, 16, na);
				mb = fx_mag(b, 16, nb);
				if (op == OP_MUL_Q8)
					r = fx_wrap(na != nb, (ma * mb) >> Q8_FRAC, 16);
				else if (mb == 0)
					r.dz = 1'b1;
				else
					r = fx_wrap(na != nb, (ma << Q8_FRAC) / mb, 16);
			end
			OP_MUL_Q16, OP_DIV_Q16: begin
				ma = fx_mag(a, 32, na);
				mb = fx_mag(b, 32, nb);
				if (op == OP_MUL_Q16)
					r = fx_wrap(na != nb, (ma * mb) >> Q16_FRAC, 32);
				else if (mb == 0)
					r.dz = 1'b1;
				else
					r = fx_wrap(na != nb, (ma << Q16_FRAC) / mb, 32);
			end
			OP_Q16_Q8: begin
				ma = fx_mag(a, 32, na);
				r = fx_wrap(na, ma >> (Q16_FRAC - Q8_FRAC), 16);
			end
			OP_Q8_Q16: begin
				ma = fx_mag(a, 16, na);
				r = fx_wrap(na, ma << (Q16_FRAC - Q8_FRAC), 32);
			end
			default: r = '0;
		endcase
		return r;
	endfunction

	initial begin
		errors  = 0;
		pending = 0;
	end

	// Queue predictions on accepted requests, compare accepted results
	always @(posedge clk) begin
		fx_result_t exp_r;
		if (arst_n) begin
			if (s_tvalid && s_tready)
				results_due.push_back(fx_compute(s_tuser, s_tdata[31:0], s_tdata[63:32]));
			if (m_tvalid && m_tready) begin
				if (results_due.size() == 0) begin
					errors++;
					$display("%0t: unexpected result word %h", $time, m_tdata);
				end else begin
					exp_r = results_due.pop_front();
					if (exp_r.value !== m_tdata) begin
						errors++;
						$display("%0t: result_value expected %h actual %h",
							$time, exp_r.value, m_tdata);
					end
					if (exp_r.dz !== m_tuser[0]) begin
						errors++;
						$display("%0t: divide_by_zero expected %b actual %b",
							$time, exp_r.dz, m_tuser[0]);
					end
					if (exp_r.ov !== m_tuser[1]) begin
						errors++;
						$display("%0t: overflowed expected %b actual %b",
							$time, exp_r.ov, m_tuser[1]);
					end
				end
			end
			pending = results_due.size();
		end
	end

endmodule
`default_nettype wire

### verif/tb_fixed_point_mul_div_unit.sv
// Testbench top for fixed_point_mul_div_unit: drives request words and result
// backpressure, and reports the verdict. Depends on fpmd_pkg, fpmd_checker and the unit.
`timescale 1ns / 100ps
`default_nettype none
module tb_fixed_point_mul_div_unit;
	import fpmd_pkg::*;

	localparam int LATENCY = 51;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [63:0] s_tdata;   // [31:0] operand_a, [63:32] operand_b
	logic [2:0]  s_tuser;   // [2:0] req_type
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;   // [31:0] result_value
	logic [1:0]  m_tuser;   // [0] divide_by_zero, [1] overflowed
	int          errors;
	int          pending;
	int          send_idle_pct;
	int          recv_stall_pct;

	fixed_point_mul_div_unit u_top (.*);

	fpmd_checker u_checker (.*);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Random backpressure on the result side
	always @(negedge clk)
		m_tready <= ($urandom_range(99) >= recv_stall_pct);

	// Present one request word and hold it until accepted
	task automatic send_req(input logic [2:0] op, input logic [31:0] a,
		input logic [31:0] b);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {b, a};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		@(negedge clk);
	endtask

	function automatic logic [31:0] rand_operand();
		case ($urandom_range(5))
			0: return $urandom;
			1: return {{16{1'b0}}, 16'($urandom)};
			2: return 32'($signed(16'($urandom)));
			3: return $urandom_range(1023) - 512;
			4: return {$urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff};
			default: return {16'($urandom_range(3) - 2), 16'($urandom)};
		endcase
	endfunction

	initial begin
		logic [31:0] corner[8];
		int          ph;
		corner = '{32'h0, 32'h1, 32'hffff_ffff, 32'h7fff_ffff, 32'h8000_0000,
			32'h0000_7fff, 32'hffff_8000, 32'h0001_0000};
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		m_tready = 1'b1;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: each operation on extremes, zero divisors, unused codes
		send_req(OP_MUL_Q8, 32'h0000_8000, 32'h0000_8000);
		send_req(OP_MUL_Q8, 32'h0000_7fff, 32'hffff_8000);
		send_req(OP_DIV_Q8, 32'h0000_0100, 32'h0001_0000);
		send_req(OP_DIV_Q8, 32'h0000_8000, 32'h0000_ffff);
		send_req(OP_MUL_Q16, 32'h8000_0000, 32'h8000_0000);
		send_req(OP_MUL_Q16, 32'h7fff_ffff, 32'hffff_ffff);
		send_req(OP_DIV_Q16, 32'h8000_0000, 32'h0);
		send_req(OP_DIV_Q16, 32'h8000_0000, 32'hffff_ffff);
		send_req(OP_DIV_Q16, 32'h0001_0000, 32'h0000_0003);
		send_req(OP_Q16_Q8, 32'h8000_0000, 32'hffff_ffff);
		send_req(OP_Q16_Q8, 32'h0000_00ff, 32'h0);
		send_req(OP_Q16_Q8, 32'hffff_ff01, 32'h0);
		send_req(OP_Q8_Q16, 32'h1234_8000, 32'h5555_aaaa);
		send_req(OP_Q8_Q16, 32'hffff_7fff, 32'h0);
		send_req(3'd6, 32'hffff_ffff, 32'hffff_ffff);
		send_req(3'd7, 32'h8000_0000, 32'h0);
		for (int i = 0; i < 8; i++)
			send_req(3'($urandom_range(5)), corner[i], corner[7 - i]);

		// Hold off until the pipeline has drained
		s_tvalid <= 1'b0;
		while (pending != 0)
			@(negedge clk);

		// Random phases with varying idle and stall mix
		for (int n = 0; n < 1900; n++) begin
			ph = n / 380;
			send_idle_pct  = (ph == 1 || ph == 3) ? (ph == 1 ? 75 : 28) : 0;
			recv_stall_pct = (ph == 2 || ph == 3) ? (ph == 2 ? 75 : 28) : 0;
			send_req(($urandom_range(19) == 0) ? 3'($urandom_range(7, 6))
				: 3'($urandom_range(5)), rand_operand(),
				($urandom_range(15) == 0) ? 32'h0 : rand_operand());
		end
		s_tvalid <= 1'b0;
		recv_stall_pct = 0;
		while (pending != 0)
			@(negedge clk);
		repeat (LATENCY + 5) @(negedge clk);
		if (errors == 0)
			$display("tb_fixed_point_mul_div_unit: done, clean");
		else
			$display("tb_fixed_point_mul_div_unit: done, errors");
		$finish;
	end

	// Run watchdog
	initial begin
		#4_000_000;
		$display("tb_fixed_point_mul_div_unit: done, errors");
		$finish;
	end

endmodule
`default_nettype wire
